### src/complex_unit_normalizer_macros.svh
// Assertion macros shared by the complex unit normalizer RTL
`ifndef COMPLEX_UNIT_NORMALIZER_MACROS_SVH
`define COMPLEX_UNIT_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define CUN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cun assertion failed");
// Next-cycle implication, disabled while in reset
`define CUN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cun assertion failed");
`else
`define CUN_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CUN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### src/cun_pkg.sv
// Shared types, constants and gain functions for the complex unit normalizer
`timescale 1ns / 1ps
`default_nettype none

package cun_pkg;

  // Result word width and rotation datapath width (Q30 plus headroom)
  localparam int unsigned OUT_W       = 24;
  localparam int unsigned ROT_W       = 33;

  // Prescale: larger magnitude ends up in [2^NORM_TOP, 2^NORM_LIM)
  localparam int unsigned NORM_TOP    = 29;
  localparam int unsigned NORM_LIM    = NORM_TOP + 1;
  localparam int unsigned NORM_STAGES = 5;

  // Q30 to Q22 rounding and saturation
  localparam int unsigned ROUND_SHIFT = 8;
  localparam int unsigned UNIT_Q22    = 1 << 22;
  localparam logic signed [ROT_W:0] ROUND_BIAS = (ROT_W + 1)'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [ROT_W:0] SAT_HI     = (ROT_W + 1)'(UNIT_Q22);
  localparam logic signed [ROT_W:0] SAT_LO     = -SAT_HI;

  // Side-band bits that travel with every word through the pipe
  typedef struct packed {
    logic valid;
    logic zero;
    logic flip;
    logic last;
  } cun_ctrl_t;

  // Integer square root, bit-pair method (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] num;
    logic [63:0] root;
    logic [63:0] bitv;
    int          i;
    num  = n;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (bitv > num) begin
        bitv = bitv >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bitv != '0) begin
        if (num >= root + bitv) begin
          num  = num - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return root;
  endfunction

  // 1/K in Q30 for the given number of micro-rotations, rounded half up
  function automatic logic [63:0] inv_gain_q30(input int unsigned steps);
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int          i;
    p = 64'h1000_0000_0000_0000;
    for (i = 0; i < int'(steps); i++) begin
      p = p + (p >> (2 * i));
    end
    k   = isqrt64(p);
    num = 64'h1000_0000_0000_0000 + (k >> 1);
    rem = '0;
    quo = '0;
    // restoring long division, one quotient bit per pass
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (k != '0 && rem >= k) begin
        rem    = rem - k;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

`default_nettype wire

### src/cun_in_if.sv
// Input stream channel: one complex sample word per handshake
`timescale 1ns / 1ps
`default_nettype none

interface cun_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;
  logic                          last_sample;

  modport source (output valid, real_part, imag_part, last_sample, input ready);
  modport sink   (input valid, real_part, imag_part, last_sample, output ready);
endinterface

`default_nettype wire

### src/cun_out_if.sv
// Output stream channel: one unit-modulus result word per handshake
`timescale 1ns / 1ps
`default_nettype none

interface cun_out_if import cun_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] unit_real;
  logic signed [OUT_W-1:0] unit_imag;
  logic                    zero_input;
  logic                    last_out;

  modport source (output valid, unit_real, unit_imag, zero_input, last_out, input ready);
  modport sink   (input valid, unit_real, unit_imag, zero_input, last_out, output ready);
endinterface

`default_nettype wire

### src/cun_prescale.sv
// Half-plane fold and staged power-of-two normalization of the input sample
`timescale 1ns / 1ps
`default_nettype none

module cun_prescale import cun_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned VW          = 34
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire logic signed [SAMPLE_BITS-1:0] real_i,
  input  wire logic signed [SAMPLE_BITS-1:0] imag_i,
  input  wire logic                          last_i,
  output      logic signed [VW-1:0]          x_o,
  output      logic signed [VW-1:0]          y_o,
  output      cun_ctrl_t                     ctrl_o
);

  logic signed [SAMPLE_BITS:0] re_x, im_x, fx, fy, ay;
  logic        [SAMPLE_BITS:0] mag;
  cun_ctrl_t                   ctrl_d;

  logic signed [VW-1:0] x_q   [NORM_STAGES+1];
  logic signed [VW-1:0] y_q   [NORM_STAGES+1];
  logic        [VW-1:0] m_q   [NORM_STAGES+1];
  cun_ctrl_t            ctrl_q[NORM_STAGES+1];

  // Fold into the right half-plane, larger magnitude of the two parts
  always_comb begin
    re_x          = {real_i[SAMPLE_BITS-1], real_i};
    im_x          = {imag_i[SAMPLE_BITS-1], imag_i};
    ctrl_d.valid  = valid_i;
    ctrl_d.flip   = real_i[SAMPLE_BITS-1];
    ctrl_d.zero   = (real_i == '0) && (imag_i == '0);
    ctrl_d.last   = last_i;
    fx            = ctrl_d.flip ? -re_x : re_x;
    fy            = ctrl_d.flip ? -im_x : im_x;
    ay            = im_x[SAMPLE_BITS] ? -im_x : im_x;
    mag           = (fx > ay) ? SAMPLE_BITS'(0) + fx : SAMPLE_BITS'(0) + ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q[0] <= '0;
    end else if (adv_i) begin
      ctrl_q[0] <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0] <= VW'(fx);
      y_q[0] <= VW'(fy);
      m_q[0] <= VW'(mag);
    end
  end

  // Shift stages: 16, 8, 4, 2, 1 while the result stays below 2^NORM_LIM
  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int unsigned K = (1 << (NORM_STAGES - 1)) >> j;
    logic do_shift;

    assign do_shift = (m_q[j][VW-1:NORM_LIM-K] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[j+1] <= '0;
      end else if (adv_i) begin
        ctrl_q[j+1] <= ctrl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[j+1] <= do_shift ? (x_q[j] <<< K) : x_q[j];
        y_q[j+1] <= do_shift ? (y_q[j] <<< K) : y_q[j];
        m_q[j+1] <= do_shift ? (m_q[j] << K)  : m_q[j];
      end
    end
  end

  assign x_o    = x_q[NORM_STAGES];
  assign y_o    = y_q[NORM_STAGES];
  assign ctrl_o = ctrl_q[NORM_STAGES];

endmodule

`default_nettype wire

### src/cun_cordic_stage.sv
// One CORDIC step: vectoring micro-rotation and the mirrored rotation of the gain vector
`timescale 1ns / 1ps
`default_nettype none

module cun_cordic_stage import cun_pkg::*; #(
  parameter int unsigned VW    = 34,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic signed [VW-1:0]    x_i,
  input  wire logic signed [VW-1:0]    y_i,
  input  wire logic signed [ROT_W-1:0] rx_i,
  input  wire logic signed [ROT_W-1:0] ry_i,
  input  wire cun_ctrl_t               ctrl_i,
  output      logic signed [VW-1:0]    x_o,
  output      logic signed [VW-1:0]    y_o,
  output      logic signed [ROT_W-1:0] rx_o,
  output      logic signed [ROT_W-1:0] ry_o,
  output      cun_ctrl_t               ctrl_o
);

  logic                    dir;
  logic signed [VW-1:0]    xs, ys, x_d, y_d;
  logic signed [ROT_W-1:0] rxs, rys, rx_d, ry_d;
  logic signed [VW-1:0]    x_q, y_q;
  logic signed [ROT_W-1:0] rx_q, ry_q;
  cun_ctrl_t               ctrl_q;

  // Direction from the sign of y; rotation turns the opposite way
  always_comb begin
    dir  = ~y_i[VW-1];
    xs   = x_i >>> SHIFT;
    ys   = y_i >>> SHIFT;
    rxs  = rx_i >>> SHIFT;
    rys  = ry_i >>> SHIFT;
    x_d  = dir ? x_i + ys   : x_i - ys;
    y_d  = dir ? y_i - xs   : y_i + xs;
    rx_d = dir ? rx_i - rys : rx_i + rys;
    ry_d = dir ? ry_i + rxs : ry_i - rxs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign rx_o   = rx_q;
  assign ry_o   = ry_q;
  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

### src/cun_round.sv
// Output stage: half-plane unfold, Q30 to Q22 rounding, saturation, result register
`timescale 1ns / 1ps
`default_nettype none

module cun_round import cun_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic signed [ROT_W-1:0] rx_i,
  input  wire logic signed [ROT_W-1:0] ry_i,
  input  wire cun_ctrl_t               ctrl_i,
  output      logic                    valid_o,
  output      logic signed [OUT_W-1:0] unit_real_o,
  output      logic signed [OUT_W-1:0] unit_imag_o,
  output      logic                    zero_o,
  output      logic                    last_o
);

  logic signed [ROT_W:0]   vx, vy, qx, qy;
  logic signed [OUT_W-1:0] re_d, im_d;
  logic                    valid_q;
  logic signed [OUT_W-1:0] re_q, im_q;
  logic                    zero_q, last_q;

  // Round half up with a floor shift, then clamp to +/-1.0
  always_comb begin
    vx = ctrl_i.flip ? -(ROT_W + 1)'(rx_i) : (ROT_W + 1)'(rx_i);
    vy = ctrl_i.flip ? -(ROT_W + 1)'(ry_i) : (ROT_W + 1)'(ry_i);
    qx = (vx + ROUND_BIAS) >>> ROUND_SHIFT;
    qy = (vy + ROUND_BIAS) >>> ROUND_SHIFT;
    if (qx > SAT_HI) begin
      qx = SAT_HI;
    end else if (qx < SAT_LO) begin
      qx = SAT_LO;
    end
    if (qy > SAT_HI) begin
      qy = SAT_HI;
    end else if (qy < SAT_LO) begin
      qy = SAT_LO;
    end
    re_d = ctrl_i.zero ? '0 : qx[OUT_W-1:0];
    im_d = ctrl_i.zero ? '0 : qy[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      re_q   <= re_d;
      im_q   <= im_d;
      zero_q <= ctrl_i.zero;
      last_q <= ctrl_i.last;
    end
  end

  assign valid_o     = valid_q;
  assign unit_real_o = re_q;
  assign unit_imag_o = im_q;
  assign zero_o      = zero_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### src/complex_unit_normalizer.sv
// Complex unit normalizer top level: z / |z| in Q1.22 via a pipelined two-phase CORDIC
//
// Takes one complex sample word per clock and returns z/|z| in Q1.22 (1.0 = 2^22),
// with a zero sample giving a zero result and zero_input set, and the last marker
// carried along. Throughput is one word per cycle while the sink takes every word.
// The pipe holds one fold stage, five normalizing shift stages, one stage per CORDIC
// micro-rotation (vectoring and gain-vector rotation share the stage) and the
// rounding/result register. The whole pipe advances together: when the result
// register holds a word that the sink does not take, in_i.ready drops and every
// stage holds its contents.
`timescale 1ns / 1ps
`default_nettype none

`include "complex_unit_normalizer_macros.svh"

module complex_unit_normalizer import cun_pkg::*; #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned CORDIC_STEPS = 22
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cun_in_if.sink     in_i,
  cun_out_if.source  out_o
);

  // Vectoring width: larger of the sample and prescale range plus gain headroom
  localparam int unsigned VW = ((SAMPLE_BITS > NORM_LIM) ? SAMPLE_BITS : NORM_LIM) + 4;
  localparam logic [63:0] INV_GAIN = inv_gain_q30(CORDIC_STEPS);
  localparam logic signed [ROT_W-1:0] RX0 = ROT_W'(INV_GAIN);

  logic adv;

  logic signed [VW-1:0]    x_s   [CORDIC_STEPS+1];
  logic signed [VW-1:0]    y_s   [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0] rx_s  [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0] ry_s  [CORDIC_STEPS+1];
  cun_ctrl_t               ctrl_s[CORDIC_STEPS+1];

  // Global advance: result register empty or being taken
  assign adv        = ~out_o.valid | out_o.ready;
  assign in_i.ready = adv;

  cun_prescale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .VW          (VW)
  ) u_prescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .real_i  (in_i.real_part),
    .imag_i  (in_i.imag_part),
    .last_i  (in_i.last_sample),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .ctrl_o  (ctrl_s[0])
  );

  // Gain vector enters the rotation chain as (1/K, 0)
  assign rx_s[0] = RX0;
  assign ry_s[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cun_cordic_stage #(
      .VW    (VW),
      .SHIFT (i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .rx_i   (rx_s[i]),
      .ry_i   (ry_s[i]),
      .ctrl_i (ctrl_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .rx_o   (rx_s[i+1]),
      .ry_o   (ry_s[i+1]),
      .ctrl_o (ctrl_s[i+1])
    );
  end

  cun_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .rx_i        (rx_s[CORDIC_STEPS]),
    .ry_i        (ry_s[CORDIC_STEPS]),
    .ctrl_i      (ctrl_s[CORDIC_STEPS]),
    .valid_o     (out_o.valid),
    .unit_real_o (out_o.unit_real),
    .unit_imag_o (out_o.unit_imag),
    .zero_o      (out_o.zero_input),
    .last_o      (out_o.last_out)
  );

  // A flagged zero sample leaves both parts at zero
  `CUN_ASSERT_IMPL(a_zero_clears, clk_i, rst_ni, out_o.valid && out_o.zero_input, out_o.unit_real == '0 && out_o.unit_imag == '0)
  // A nonzero sample never normalizes to the origin
  `CUN_ASSERT_IMPL(a_unit_nonzero, clk_i, rst_ni, out_o.valid && !out_o.zero_input, out_o.unit_real != '0 || out_o.unit_imag != '0)
  // A held result word freezes the input side
  `CUN_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  // While the input is blocked the pending word is still offered next cycle
  `CUN_ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, !in_i.ready, out_o.valid)

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the complex unit normalizer (z / |z| in Q1.22)
`timescale 1ns / 1ps

module tb;
  import cun_pkg::*;

  localparam int SAMPLE_BITS  = 24;
  localparam int CORDIC_STEPS = 22;
  localparam int RANDOM_WORDS = 1200;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;
  localparam int MAX_PRINTS   = 50;

  // One input sample and one expected result word
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } sample_word_t;

  typedef struct {
    logic signed [OUT_W-1:0] unit_real;
    logic signed [OUT_W-1:0] unit_imag;
    logic                    zero_input;
    logic                    last_out;
  } unit_word_t;

  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_HALF   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_MOSTLY = 2'd3
  } rx_mode_e;

  logic clk;
  logic rst_n;

  cun_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  cun_out_if                             out_ch ();

  complex_unit_normalizer #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  sample_word_t sample_q[$];
  unit_word_t   unit_q[$];
  longint       inv_gain_q30;
  int           total_words;
  int           sent_cnt;
  int           got_cnt;
  int           err_cnt;

  // 125 MHz clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // 1/K in Q30: K^2 accumulated in Q60, bitwise square root, rounded division
  function automatic longint calc_inv_gain();
    longint unsigned p;
    longint unsigned root;
    longint unsigned trial;
    int              i;
    p    = 64'd1 << 60;
    root = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      p = p + (p >> (2 * i));
    end
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= p) begin
        root = trial;
      end
    end
    return longint'(((64'd1 << 60) + root / 2) / root);
  endfunction

  // Q30 to Q22 with half-up rounding, then clamp to +/-1.0
  function automatic logic signed [OUT_W-1:0] round_to_q22(input longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > longint'(UNIT_Q22)) begin
      r = longint'(UNIT_Q22);
    end
    if (r < -longint'(UNIT_Q22)) begin
      r = -longint'(UNIT_Q22);
    end
    return r[OUT_W-1:0];
  endfunction

  // Expected unit vector: fold, prescale, vectoring, then replay on (1/K, 0)
  function automatic unit_word_t normalize_sample(input logic signed [SAMPLE_BITS-1:0] re,
                                                  input logic signed [SAMPLE_BITS-1:0] im,
                                                  input logic last);
    unit_word_t             w;
    longint                 x;
    longint                 y;
    longint                 m;
    longint                 xs;
    longint                 ys;
    longint                 rx;
    longint                 ry;
    logic                   flip;
    logic [CORDIC_STEPS-1:0] ccw_mask;
    int                     i;
    w.last_out = last;
    x = re;
    y = im;
    if (x == 0 && y == 0) begin
      w.unit_real  = '0;
      w.unit_imag  = '0;
      w.zero_input = 1'b1;
      return w;
    end
    w.zero_input = 1'b0;
    flip = (x < 0);
    if (flip) begin
      x = -x;
      y = -y;
    end
    m = (y < 0) ? -y : y;
    if (x > m) begin
      m = x;
    end
    while (m < (longint'(1) << 29)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    // drive y to zero and note each turn
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      ccw_mask[i] = (y >= 0);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
      end else begin
        x = x - ys;
        y = y + xs;
      end
    end
    // undo the same turns on the gain-compensated unit vector
    rx = inv_gain_q30;
    ry = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = rx >>> i;
      ys = ry >>> i;
      if (ccw_mask[i]) begin
        rx = rx - ys;
        ry = ry + xs;
      end else begin
        rx = rx + ys;
        ry = ry - xs;
      end
    end
    if (flip) begin
      rx = -rx;
      ry = -ry;
    end
    w.unit_real = round_to_q22(rx);
    w.unit_imag = round_to_q22(ry);
    return w;
  endfunction

  task automatic add_sample(input longint re, input longint im, input logic last);
    sample_word_t s;
    s.re   = re[SAMPLE_BITS-1:0];
    s.im   = im[SAMPLE_BITS-1:0];
    s.last = last;
    sample_q.push_back(s);
  endtask

  // Signed value of random magnitude class: w significant bits
  function automatic longint rand_signed(input int w);
    longint v;
    v = longint'($urandom) & ((longint'(1) << w) - 1);
    if (v[w-1]) begin
      v = v - (longint'(1) << w);
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t: mismatch on word %0d: %s got %0d expected %0d",
               $time, got_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk or negedge rst_n) begin : sender
    sample_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unit_q.push_back(normalize_sample(in_ch.real_part, in_ch.imag_part,
                                          in_ch.last_sample));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          in_ch.real_part   <= nxt.re;
          in_ch.imag_part   <= nxt.im;
          in_ch.last_sample <= nxt.last;
          in_ch.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn each time the 6-bit mode counter wraps, plus one long hold-off
  rx_mode_e rx_mode;
  logic [5:0] mode_cnt;
  int         hold_left;
  logic       hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      <= RX_ALWAYS;
      mode_cnt     <= '0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      mode_cnt <= mode_cnt + 1'b1;
      if (mode_cnt == '1) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && got_cnt >= HOLD_AFTER) begin
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= ($urandom_range(0, 1) != 0);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Monitor: check each taken word against the oldest expectation
  always @(posedge clk) begin : monitor
    unit_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (unit_q.size() == 0) begin
        report_mismatch("unexpected word, unit_real", out_ch.unit_real, 0);
      end else begin
        want = unit_q.pop_front();
        if (out_ch.unit_real !== want.unit_real) begin
          report_mismatch("unit_real", out_ch.unit_real, want.unit_real);
        end
        if (out_ch.unit_imag !== want.unit_imag) begin
          report_mismatch("unit_imag", out_ch.unit_imag, want.unit_imag);
        end
        if (out_ch.zero_input !== want.zero_input) begin
          report_mismatch("zero_input", out_ch.zero_input, want.zero_input);
        end
        if (out_ch.last_out !== want.last_out) begin
          report_mismatch("last_out", out_ch.last_out, want.last_out);
        end
      end
      got_cnt <= got_cnt + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int drain;
    int pick;
    int w;
    in_ch.valid       = 1'b0;
    in_ch.real_part   = '0;
    in_ch.imag_part   = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    sent_cnt          = 0;
    got_cnt           = 0;
    err_cnt           = 0;
    inv_gain_q30      = calc_inv_gain();

    // zero samples, field extremes, axes, diagonals, left half-plane
    add_sample(0, 0, 1'b0);
    add_sample(0, 0, 1'b1);
    add_sample(8388607, 0, 1'b0);
    add_sample(-8388608, 0, 1'b1);
    add_sample(0, 8388607, 1'b0);
    add_sample(0, -8388608, 1'b0);
    add_sample(-8388608, -8388608, 1'b0);
    add_sample(8388607, 8388607, 1'b0);
    add_sample(8388607, -8388608, 1'b0);
    add_sample(-8388608, 8388607, 1'b1);
    add_sample(1, 0, 1'b0);
    add_sample(0, 1, 1'b0);
    add_sample(-1, 0, 1'b0);
    add_sample(0, -1, 1'b1);
    add_sample(1, 1, 1'b0);
    add_sample(-1, -1, 1'b0);
    add_sample(-1, 1, 1'b0);
    add_sample(1, -1, 1'b0);
    add_sample(-3, 7, 1'b0);
    add_sample(4194304, -12345, 1'b0);
    add_sample(-7, -8388608, 1'b0);
    add_sample(3, 4, 1'b1);

    // random samples over all magnitude classes
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      w    = $urandom_range(1, SAMPLE_BITS);
      case (pick)
        0: add_sample(0, 0, $urandom_range(0, 1) != 0);
        1: add_sample(0, rand_signed(w), $urandom_range(0, 15) == 0);
        2: add_sample(rand_signed(w), 0, $urandom_range(0, 15) == 0);
        3: begin
          longint v;
          v = rand_signed(w);
          add_sample(v, ($urandom_range(0, 1) != 0) ? v : -v, $urandom_range(0, 15) == 0);
        end
        4, 5, 6, 7: add_sample(rand_signed(SAMPLE_BITS), rand_signed(SAMPLE_BITS),
                               $urandom_range(0, 15) == 0);
        default: add_sample(rand_signed(w), rand_signed($urandom_range(1, SAMPLE_BITS)),
                            $urandom_range(0, 15) == 0);
      endcase
    end
    total_words = sample_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt != total_words) @(posedge clk);
    drain = 0;
    while (unit_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (CORDIC_STEPS + 20) @(posedge clk);
    if (unit_q.size() != 0) begin
      report_mismatch("words never returned", unit_q.size(), 0);
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/cun_pkg.sv
src/cun_in_if.sv
src/cun_out_if.sv
src/cun_prescale.sv
src/cun_cordic_stage.sv
src/cun_round.sv
src/complex_unit_normalizer.sv
tb/tb.sv
